FILE: design/websocket_frame_deframer_assert.svh
// Assertion macros for the WebSocket frame deframer.
`ifndef WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define WSD_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define WSD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define WSD_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define WSD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

FILE: design/wsd_pkg.sv
// Types and constants shared by the WebSocket frame deframer modules.
package wsd_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned LEN_W  = 16;
    localparam int unsigned KEY_W  = 32;

    localparam logic [LEN_W-1:0] MAX_LENGTH_RESET = 16'd1024;

    // Header opcodes (low nibble of the first byte)
    localparam logic [3:0] OP_TEXT  = 4'h1;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;
    localparam logic [3:0] OP_PONG  = 4'hA;

    // 7-bit length codes that select extended forms
    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;

    typedef enum logic [2:0] {
        KIND_DATA  = 3'd0,
        KIND_EMPTY = 3'd1,
        KIND_PONG  = 3'd2,
        KIND_CLOSE = 3'd3,
        KIND_PSEEN = 3'd4,
        KIND_BADOP = 3'd5,
        KIND_LEN64 = 3'd6,
        KIND_LONG  = 3'd7
    } kind_t;

    typedef enum logic [8:0] {
        PH_HEADER  = 9'b000000001,
        PH_LEN     = 9'b000000010,
        PH_EXT_HI  = 9'b000000100,
        PH_EXT_LO  = 9'b000001000,
        PH_MASK0   = 9'b000010000,
        PH_MASK1   = 9'b000100000,
        PH_MASK2   = 9'b001000000,
        PH_MASK3   = 9'b010000000,
        PH_PAYLOAD = 9'b100000000
    } phase_t;

    typedef struct packed {
        kind_t             kind;
        logic [BYTE_W-1:0] data;
        logic              last;
    } result_t;

endpackage

FILE: design/wsd_parser.sv
// Frame parser: per-byte phase logic, frame length, mask key and unmasking.
module wsd_parser (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    fire,
    input  logic [7:0]              rx_byte,
    input  logic [15:0]             max_length,
    output logic                    res_valid,
    output wsd_pkg::result_t        res
);
    import wsd_pkg::*;

    phase_t             phase_reg,   phase_next;
    logic               masked_reg,  masked_next;
    logic [LEN_W-1:0]   len_reg,     len_next;
    logic [LEN_W-1:0]   seen_reg,    seen_next;
    logic [KEY_W-1:0]   key_reg,     key_next;

    logic               len_known;
    logic [LEN_W-1:0]   len_val;
    logic [LEN_W-1:0]   seen_inc;
    logic [BYTE_W-1:0]  key_byte;

    always_comb begin
        case (seen_reg[1:0])
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    assign seen_inc = seen_reg + 16'd1;

    always_comb begin
        phase_next  = phase_reg;
        masked_next = masked_reg;
        len_next    = len_reg;
        seen_next   = seen_reg;
        key_next    = key_reg;
        len_known   = 1'b0;
        len_val     = len_reg;
        res_valid   = 1'b0;
        res         = '{kind: KIND_DATA, data: '0, last: 1'b0};

        case (phase_reg)
            PH_LEN: begin
                masked_next = rx_byte[7];
                if (rx_byte[6:0] == LEN7_EXT64) begin
                    phase_next = PH_HEADER;
                    res_valid  = 1'b1;
                    res.kind   = KIND_LEN64;
                end else if (rx_byte[6:0] == LEN7_EXT16) begin
                    phase_next = PH_EXT_HI;
                end else begin
                    len_val   = {9'd0, rx_byte[6:0]};
                    len_known = 1'b1;
                end
            end
            PH_EXT_HI: begin
                len_next   = {rx_byte, 8'd0};
                phase_next = PH_EXT_LO;
            end
            PH_EXT_LO: begin
                len_val   = {len_reg[15:8], rx_byte};
                len_known = 1'b1;
            end
            PH_MASK0: begin
                key_next   = {key_reg[23:0], rx_byte};
                phase_next = PH_MASK1;
            end
            PH_MASK1: begin
                key_next   = {key_reg[23:0], rx_byte};
                phase_next = PH_MASK2;
            end
            PH_MASK2: begin
                key_next   = {key_reg[23:0], rx_byte};
                phase_next = PH_MASK3;
            end
            PH_MASK3: begin
                key_next = {key_reg[23:0], rx_byte};
                if (len_reg == '0) begin
                    phase_next = PH_HEADER;
                    res_valid  = 1'b1;
                    res.kind   = KIND_EMPTY;
                    res.last   = 1'b1;
                end else begin
                    phase_next = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                seen_next = seen_inc;
                res_valid = 1'b1;
                res.kind  = KIND_DATA;
                res.data  = rx_byte ^ key_byte;
                res.last  = (seen_inc >= len_reg);
                if (seen_inc >= len_reg) begin
                    phase_next = PH_HEADER;
                end
            end
            default: begin
                // header byte; unknown phase codes land here too
                phase_next = PH_HEADER;
                res_valid  = 1'b1;
                case (rx_byte[3:0])
                    OP_CLOSE: res.kind = KIND_CLOSE;
                    OP_PING:  res.kind = KIND_PONG;
                    OP_PONG:  res.kind = KIND_PSEEN;
                    OP_TEXT: begin
                        phase_next = PH_LEN;
                        res_valid  = 1'b0;
                    end
                    default:  res.kind = KIND_BADOP;
                endcase
            end
        endcase

        if (len_known) begin
            len_next = len_val;
            if (len_val >= max_length) begin
                phase_next = PH_HEADER;
                res_valid  = 1'b1;
                res.kind   = KIND_LONG;
            end else begin
                seen_next = '0;
                key_next  = '0;
                if (masked_next) begin
                    phase_next = PH_MASK0;
                end else if (len_val == '0) begin
                    phase_next = PH_HEADER;
                    res_valid  = 1'b1;
                    res.kind   = KIND_EMPTY;
                    res.last   = 1'b1;
                end else begin
                    phase_next = PH_PAYLOAD;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HEADER;
            masked_reg <= 1'b0;
            len_reg    <= '0;
            seen_reg   <= '0;
            key_reg    <= '0;
        end else if (fire) begin
            phase_reg  <= phase_next;
            masked_reg <= masked_next;
            len_reg    <= len_next;
            seen_reg   <= seen_next;
            key_reg    <= key_next;
        end
    end

endmodule

FILE: design/wsd_out_stage.sv
// Result register toward the output stream.
module wsd_out_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  wsd_pkg::result_t    res_in,
    input  logic                m_tready,
    output logic                m_tvalid,
    output wsd_pkg::result_t    res_out,
    output logic                free
);
    import wsd_pkg::*;

    logic    valid_reg, valid_next;
    result_t res_reg;

    assign free     = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign res_out  = res_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res_in;
        end
    end

endmodule

FILE: design/websocket_frame_deframer.sv
// Top level of the WebSocket frame deframer (text frames, unmasking, control reports).
//
//   channel  | dir | handshake          | content
//   s_       | in  | s_tvalid/s_tready  | tdata[7:0] rx_byte
//   m_       | out | m_tvalid/m_tready  | tdata[7:0] data_byte, tuser[2:0] kind, tlast last
//   cfg_     | in  | cfg_we             | cfg_wdata[15:0] max_length
//
// One byte per cycle while results are taken; a byte passes from s_ to m_ through
// the input register, then the result register after the phase logic.
// Reset is synchronous on aresetn low: parser back to header, max_length 1024.
// A byte that gives no result moves on even while m_ is stalled; a byte that
// gives a result waits in the input register until the result register frees.
module websocket_frame_deframer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] data_byte
    output logic [2:0]  m_tuser,    // [2:0] kind
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);
    import wsd_pkg::*;

`include "websocket_frame_deframer_assert.svh"

    logic [LEN_W-1:0]  max_length_reg;
    logic              in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0] in_byte_reg;

    logic              res_valid;
    result_t           res;
    result_t           res_out;
    logic              out_free;
    logic              advance;
    logic              s_accept;

    assign advance  = in_valid_reg && (!res_valid || out_free);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            max_length_reg <= MAX_LENGTH_RESET;
        end else begin
            in_valid_reg <= in_valid_next;
            if (cfg_we) begin
                max_length_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_byte_reg <= s_tdata;
        end
    end

    wsd_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fire       (advance),
        .rx_byte    (in_byte_reg),
        .max_length (max_length_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    wsd_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance && res_valid),
        .res_in   (res),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .res_out  (res_out),
        .free     (out_free)
    );

    assign m_tdata = res_out.data;
    assign m_tuser = res_out.kind;
    assign m_tlast = res_out.last;

    // Only payload bytes carry data.
    `WSD_ASSERT_IMPL(a_data_zero, aclk, aresetn,
        m_tvalid && (m_tuser != KIND_DATA), m_tdata == 8'd0, "data set on non-payload result")
    // tlast only on payload or empty message, and always on empty message.
    `WSD_ASSERT_IMPL(a_last_kind, aclk, aresetn,
        m_tvalid && m_tlast, (m_tuser == KIND_DATA) || (m_tuser == KIND_EMPTY),
        "tlast on a report result")
    `WSD_ASSERT_IMPL(a_empty_last, aclk, aresetn,
        m_tvalid && (m_tuser == KIND_EMPTY), m_tlast, "empty message without tlast")
    // A byte that produces a result always lands in the result register.
    `WSD_ASSERT_NEXT(a_load_shows, aclk, aresetn,
        advance && res_valid, m_tvalid, "result lost on its way out")

endmodule
